// File: rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond holds at every clock edge.
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that cons holds at every clock edge at which ante holds.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cfa_pkg.sv
package cfa_pkg;

    localparam int DW_DEFAULT = 64;
    localparam int STAGES     = 67;
    localparam int DIV_STEPS  = 64;
    localparam int MUL_DONE   = 4;
    localparam int DIV_FIX    = DIV_STEPS + 1;
    localparam int FIT_STAGE  = DIV_STEPS + 2;

    typedef enum logic [4:0] {
        ACT_ADD  = 5'd0,
        ACT_SUB  = 5'd1,
        ACT_MUL  = 5'd2,
        ACT_DIV  = 5'd3,
        ACT_MOD  = 5'd4,
        ACT_AND  = 5'd5,
        ACT_OR   = 5'd6,
        ACT_XOR  = 5'd7,
        ACT_SHL  = 5'd8,
        ACT_SHR  = 5'd9,
        ACT_EQ   = 5'd10,
        ACT_NE   = 5'd11,
        ACT_LT   = 5'd12,
        ACT_GT   = 5'd13,
        ACT_LE   = 5'd14,
        ACT_GE   = 5'd15,
        ACT_LAND = 5'd16,
        ACT_LOR  = 5'd17
    } action_t;

    localparam logic [1:0] KIND_BOOL = 2'd1;
    localparam logic [1:0] KIND_SINT = 2'd2;

    typedef struct packed {
        logic [4:0]         act;
        logic signed [63:0] res;
        logic               ok;
        logic               chk;
        logic [1:0]         kind;
        logic [3:0]         bytes;
        logic               neg_q;
        logic               neg_a;
    } item_t;

endpackage

// File: rtl/core/cfa_div_pipe.sv
module cfa_div_pipe
    import cfa_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_STEPS-1:0] ld,
    input  logic [63:0]          dividend,
    input  logic [63:0]          divisor,
    output logic [63:0]          quot,
    output logic [63:0]          rem
);

    logic [63:0] q_reg [DIV_STEPS];
    logic [63:0] r_reg [DIV_STEPS];
    logic [63:0] d_reg [DIV_STEPS];
    logic [63:0] q_next [DIV_STEPS];
    logic [63:0] r_next [DIV_STEPS];
    logic [63:0] d_next [DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++)
        begin : g_step
            logic [63:0] q_in;
            logic [63:0] r_in;
            logic [64:0] trial;
            logic        ge;

            if (j == 0)
            begin : g_first
                assign q_in      = dividend;
                assign r_in      = '0;
                assign d_next[j] = divisor;
            end
            else
            begin : g_rest
                assign q_in      = q_reg[j-1];
                assign r_in      = r_reg[j-1];
                assign d_next[j] = d_reg[j-1];
            end

            always_comb
            begin
                trial     = {r_in, q_in[63]};
                ge        = trial >= {1'b0, d_next[j]};
                r_next[j] = ge ? 64'(trial - {1'b0, d_next[j]}) : trial[63:0];
                q_next[j] = {q_in[62:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (ld[j])
                begin
                    q_reg[j] <= q_next[j];
                    r_reg[j] <= r_next[j];
                    d_reg[j] <= d_next[j];
                end
            end
        end
    endgenerate

    assign quot = q_reg[DIV_STEPS-1];
    assign rem  = r_reg[DIV_STEPS-1];

endmodule

// File: rtl/core/checked_constant_fold_alu.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    action, left_operand, right_operand,
//                               operands_signed, result_kind, result_bytes
// out      out_valid/out_ready  folded_value, foldable
//
// One item enters per cycle while in_ready is high; the 64-step divider
// pipeline sets the depth; the 64x64 product is four 32x32 multipliers.
// Async active-low reset clears the stage valid bits only.
// Bubbles collapse: a stage loads whenever it is empty or the next one moves,
// so a held output blocks input only once every stage holds an item.
module checked_constant_fold_alu
    import cfa_pkg::*;
#(
    parameter int DATA_WIDTH = DW_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         action,
    input  logic signed [63:0] left_operand,
    input  logic signed [63:0] right_operand,
    input  logic               operands_signed,
    input  logic [1:0]         result_kind,
    input  logic [3:0]         result_bytes,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] folded_value,
    output logic               foldable
);

    localparam logic signed [63:0] INT_MIN = {1'b1, 63'd0};

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] ld;
    item_t             item_reg  [STAGES];
    item_t             item_next [STAGES];

    logic [63:0]  abs_a_reg, abs_b_reg, abs_a_next, abs_b_next;
    logic [63:0]  pp_reg [4];
    logic [64:0]  mid_reg;
    logic [63:0]  lo_reg, hi_reg;
    logic [127:0] prod_reg;

    logic [63:0] quot, rem;

    // stall chain
    always_comb
    begin
        ld[STAGES-1] = !v_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_ready = ld[0];

    // stage 0: simple ops, operand magnitudes
    item_t       s0;
    logic [63:0] sum, dif;
    logic        shift_ok;
    always_comb
    begin
        s0       = '0;
        sum      = 64'(left_operand + right_operand);
        dif      = 64'(left_operand - right_operand);
        shift_ok = operands_signed && !left_operand[63] && right_operand[63:6] == '0
                   && right_operand[5:0] != 6'd63;
        s0.act   = action;
        s0.kind  = result_kind;
        s0.bytes = result_bytes;
        s0.neg_q = left_operand[63] ^ right_operand[63];
        s0.neg_a = left_operand[63];
        s0.chk   = 1'b1;
        case (action)
            ACT_ADD:
            begin
                s0.res = sum;
                s0.ok  = operands_signed && !(left_operand[63] == right_operand[63]
                         && sum[63] != left_operand[63]);
            end
            ACT_SUB:
            begin
                s0.res = dif;
                s0.ok  = operands_signed && !(left_operand[63] != right_operand[63]
                         && dif[63] != left_operand[63]);
            end
            ACT_MUL: s0.ok = operands_signed;
            ACT_DIV, ACT_MOD:
                s0.ok = operands_signed && right_operand != '0
                        && !(left_operand == INT_MIN && right_operand == '1);
            ACT_AND:
            begin
                s0.res = left_operand & right_operand;
                s0.ok  = operands_signed;
            end
            ACT_OR:
            begin
                s0.res = left_operand | right_operand;
                s0.ok  = operands_signed;
            end
            ACT_XOR:
            begin
                s0.res = left_operand ^ right_operand;
                s0.ok  = operands_signed;
            end
            ACT_SHL:
            begin
                s0.res = left_operand << right_operand[5:0];
                s0.ok  = shift_ok
                         && (left_operand >> (6'd63 - right_operand[5:0])) == '0;
            end
            ACT_SHR:
            begin
                s0.res = left_operand >> right_operand[5:0];
                s0.ok  = shift_ok;
            end
            ACT_EQ:
            begin
                s0.res = 64'(left_operand == right_operand);
                s0.ok  = 1'b1;
                s0.chk = 1'b0;
            end
            ACT_NE:
            begin
                s0.res = 64'(left_operand != right_operand);
                s0.ok  = 1'b1;
                s0.chk = 1'b0;
            end
            ACT_LT:
            begin
                s0.res = 64'(left_operand < right_operand);
                s0.ok  = operands_signed;
                s0.chk = 1'b0;
            end
            ACT_GT:
            begin
                s0.res = 64'(left_operand > right_operand);
                s0.ok  = operands_signed;
                s0.chk = 1'b0;
            end
            ACT_LE:
            begin
                s0.res = 64'(left_operand <= right_operand);
                s0.ok  = operands_signed;
                s0.chk = 1'b0;
            end
            ACT_GE:
            begin
                s0.res = 64'(left_operand >= right_operand);
                s0.ok  = operands_signed;
                s0.chk = 1'b0;
            end
            ACT_LAND:
            begin
                s0.res = 64'(left_operand != '0 && right_operand != '0);
                s0.ok  = 1'b1;
                s0.chk = 1'b0;
            end
            ACT_LOR:
            begin
                s0.res = 64'(left_operand != '0 || right_operand != '0);
                s0.ok  = 1'b1;
                s0.chk = 1'b0;
            end
            default: s0.ok = 1'b0;
        endcase
        abs_a_next = left_operand[63] ? 64'(-left_operand) : left_operand;
        abs_b_next = right_operand[63] ? 64'(-right_operand) : right_operand;
    end

    // multiplier lane
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            abs_a_reg <= abs_a_next;
            abs_b_reg <= abs_b_next;
        end
        if (ld[1])
        begin
            pp_reg[0] <= 64'(abs_a_reg[31:0])  * 64'(abs_b_reg[31:0]);
            pp_reg[1] <= 64'(abs_a_reg[63:32]) * 64'(abs_b_reg[31:0]);
            pp_reg[2] <= 64'(abs_a_reg[31:0])  * 64'(abs_b_reg[63:32]);
            pp_reg[3] <= 64'(abs_a_reg[63:32]) * 64'(abs_b_reg[63:32]);
        end
        if (ld[2])
        begin
            mid_reg <= {1'b0, pp_reg[1]} + {1'b0, pp_reg[2]};
            lo_reg  <= pp_reg[0];
            hi_reg  <= pp_reg[3];
        end
        if (ld[3])
        begin
            prod_reg <= {hi_reg, lo_reg} + {31'd0, mid_reg, 32'd0};
        end
    end

    cfa_div_pipe u_div (
        .clk      (clk),
        .ld       (ld[DIV_STEPS:1]),
        .dividend (abs_a_reg),
        .divisor  (abs_b_reg),
        .quot     (quot),
        .rem      (rem)
    );

    // stage advance, with mul finish, div sign fix and fit check
    logic        mul_fit;
    logic [63:0] mul_val;
    logic [6:0]  bits;
    logic [5:0]  sh;
    logic signed [63:0] top;
    logic        fits;
    always_comb
    begin
        item_next[0] = s0;
        for (int k = 1; k < STAGES; k++)
        begin
            item_next[k] = item_reg[k-1];
        end

        mul_val = item_reg[MUL_DONE-1].neg_q ? 64'(-prod_reg[63:0]) : prod_reg[63:0];
        mul_fit = item_reg[MUL_DONE-1].neg_q
                  ? (prod_reg[127:64] == '0 && (!prod_reg[63] || prod_reg[62:0] == '0))
                  : prod_reg[127:63] == '0;
        if (item_reg[MUL_DONE-1].act == ACT_MUL)
        begin
            item_next[MUL_DONE].res = mul_val;
            item_next[MUL_DONE].ok  = item_reg[MUL_DONE-1].ok && mul_fit;
        end

        if (item_reg[DIV_FIX-1].act == ACT_DIV)
        begin
            item_next[DIV_FIX].res = item_reg[DIV_FIX-1].neg_q ? 64'(-quot) : quot;
        end
        else if (item_reg[DIV_FIX-1].act == ACT_MOD)
        begin
            item_next[DIV_FIX].res = item_reg[DIV_FIX-1].neg_a ? 64'(-rem) : rem;
        end

        bits = {item_reg[FIT_STAGE-1].bytes, 3'b000};
        sh   = 6'(bits - 7'd1);
        top  = item_reg[FIT_STAGE-1].res >>> sh;
        fits = 1'b0;
        if (item_reg[FIT_STAGE-1].kind == KIND_BOOL)
        begin
            fits = item_reg[FIT_STAGE-1].res == 64'sd0 || item_reg[FIT_STAGE-1].res == 64'sd1;
        end
        else if (item_reg[FIT_STAGE-1].kind == KIND_SINT)
        begin
            fits = bits != 7'd0 && bits <= 7'(DATA_WIDTH)
                   && (bits == 7'd64 || top == '0 || top == '1);
        end
        if (item_reg[FIT_STAGE-1].chk)
        begin
            item_next[FIT_STAGE].ok = item_reg[FIT_STAGE-1].ok && fits;
        end
        if (!item_next[FIT_STAGE].ok)
        begin
            item_next[FIT_STAGE].res = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (ld[k])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

    assign out_valid    = v_reg[STAGES-1];
    assign folded_value = item_reg[STAGES-1].res;
    assign foldable     = item_reg[STAGES-1].ok;

`include "assert_macros.svh"

    `CHK_IMPLY(a_refused_zero, out_valid && !foldable, folded_value == '0,
        "refused item carries nonzero value")
    `CHK_IMPLY(a_ready_when_empty, !out_valid, in_ready,
        "input stalled with empty output stage")
    `CHK_IMPLY(a_bool_range, out_valid && foldable && item_reg[STAGES-1].chk
        && item_reg[STAGES-1].kind == KIND_BOOL, folded_value[63:1] == '0,
        "bool result out of range")

endmodule

// File: bench/fold_checker.sv
`timescale 1ns / 1ps
module fold_checker
    import cfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [4:0]         action,
    input  logic signed [63:0] left_operand,
    input  logic signed [63:0] right_operand,
    input  logic               operands_signed,
    input  logic [1:0]         result_kind,
    input  logic [3:0]         result_bytes,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [63:0] folded_value,
    input  logic               foldable,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [63:0] value;
        logic               ok;
    } fold_t;

    fold_t folds_due[$];

    function automatic bit fits_type(logic [1:0] kind, logic [3:0] nbytes, longint v);
        int     bits;
        longint lim;
        bits = nbytes * 8;
        if (kind == KIND_BOOL) return v == 0 || v == 1;
        if (kind != KIND_SINT) return 0;
        if (bits == 0 || bits > 64) return 0;
        if (bits == 64) return 1;
        lim = 64'sd1 <<< (bits - 1);
        return v >= -lim && v <= lim - 1;
    endfunction

    function automatic fold_t fold_op(logic [4:0] act, longint a, longint b, bit sg,
                                      logic [1:0] kind, logic [3:0] nbytes);
        fold_t           f;
        logic [127:0]    wide;
        logic signed [64:0] s65;
        bit              ok;
        bit              chk;
        longint          r;
        r = 0;
        ok = 0;
        chk = 1;
        case (act)
            ACT_ADD, ACT_SUB:
            begin
                s65 = (act == ACT_ADD) ? ({a[63], a} + {b[63], b}) : ({a[63], a} - {b[63], b});
                r = s65[63:0];
                ok = sg && (s65[64] == s65[63]);
            end
            ACT_MUL:
            begin
                wide = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                r = wide[63:0];
                ok = sg && (wide[127:63] == {65{wide[63]}});
            end
            ACT_DIV, ACT_MOD:
            begin
                if (sg && b != 0 && !(a == SMIN && b == -1))
                begin
                    r = (act == ACT_DIV) ? a / b : a % b;
                    ok = 1;
                end
            end
            ACT_AND: begin r = a & b; ok = sg; end
            ACT_OR:  begin r = a | b; ok = sg; end
            ACT_XOR: begin r = a ^ b; ok = sg; end
            ACT_SHL:
            begin
                if (sg && a >= 0 && b >= 0 && b < 63 && a <= (SMAX >>> b))
                begin
                    r = a <<< b;
                    ok = 1;
                end
            end
            ACT_SHR:
            begin
                if (sg && a >= 0 && b >= 0 && b < 63)
                begin
                    r = a >>> b;
                    ok = 1;
                end
            end
            ACT_EQ:   begin r = a == b; ok = 1; chk = 0; end
            ACT_NE:   begin r = a != b; ok = 1; chk = 0; end
            ACT_LT:   begin r = a < b; ok = sg; chk = 0; end
            ACT_GT:   begin r = a > b; ok = sg; chk = 0; end
            ACT_LE:   begin r = a <= b; ok = sg; chk = 0; end
            ACT_GE:   begin r = a >= b; ok = sg; chk = 0; end
            ACT_LAND: begin r = (a != 0 && b != 0); ok = 1; chk = 0; end
            ACT_LOR:  begin r = (a != 0 || b != 0); ok = 1; chk = 0; end
            default:  ok = 0;
        endcase
        if (ok && chk) ok = fits_type(kind, nbytes, r);
        f.value = ok ? r : 64'sd0;
        f.ok = ok;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fold_t exp_f;
        int    errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && in_ready)
                folds_due.push_back(fold_op(action, left_operand, right_operand,
                                            operands_signed, result_kind, result_bytes));
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (folds_due.size() == 0)
                begin
                    $error("result with nothing expected: folded_value %0d", folded_value);
                    errs = errs + 1;
                end
                else
                begin
                    exp_f = folds_due.pop_front();
                    if (folded_value !== exp_f.value)
                    begin
                        $error("folded_value expected %0d actual %0d", exp_f.value, folded_value);
                        errs = errs + 1;
                    end
                    if (foldable !== exp_f.ok)
                    begin
                        $error("foldable expected %0d actual %0d", exp_f.ok, foldable);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= folds_due.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import cfa_pkg::*;

    localparam int LATENCY = STAGES;
    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [4:0]         action = 0;
    logic signed [63:0] left_operand = 0;
    logic signed [63:0] right_operand = 0;
    logic               operands_signed = 0;
    logic [1:0]         result_kind = 0;
    logic [3:0]         result_bytes = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [63:0] folded_value;
    logic               foldable;
    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 send_idle = 0;
    int                 recv_idle = 0;
    int                 hold_cycles = 0;
    int                 items_sent = 0;

    always #4 clk = ~clk;

    checked_constant_fold_alu uut (.*);
    fold_checker chk (.*);

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic longint pick_operand();
        case ($urandom_range(9))
            0: return SMAX;
            1: return SMIN;
            2: return $urandom_range(70);
            3: return -longint'($urandom_range(70));
            4: return longint'($urandom_range(2000)) - 1000;
            5: return {32'h0, $urandom()};
            6: return -longint'({32'h0, $urandom()});
            7: return longint'($urandom_range(62)) << $urandom_range(62);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_item(logic [4:0] act, longint a, longint b, bit sg,
                             logic [1:0] kind, logic [3:0] nbytes);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        action <= act;
        left_operand <= a;
        right_operand <= b;
        operands_signed <= sg;
        result_kind <= kind;
        result_bytes <= nbytes;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_random(int n);
        logic [1:0] kind;
        for (int i = 0; i < n; i++)
        begin
            kind = ($urandom_range(9) < 7) ? KIND_SINT : 2'($urandom_range(3));
            send_item($urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(17)),
                      pick_operand(), pick_operand(), $urandom_range(9) != 0, kind,
                      $urandom_range(3) == 0 ? 4'($urandom_range(15)) :
                      4'(1 << $urandom_range(3)));
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_item(ACT_ADD, SMAX, 1, 1, KIND_SINT, 8);
        send_item(ACT_ADD, SMAX, 0, 1, KIND_SINT, 8);
        send_item(ACT_SUB, SMIN, 1, 1, KIND_SINT, 8);
        send_item(ACT_MUL, SMIN, -1, 1, KIND_SINT, 8);
        send_item(ACT_MUL, 64'sh1_0000_0000, 64'sh7FFF_FFFF, 1, KIND_SINT, 8);
        send_item(ACT_DIV, 7, 0, 1, KIND_SINT, 8);
        send_item(ACT_DIV, SMIN, -1, 1, KIND_SINT, 8);
        send_item(ACT_DIV, -7, 2, 1, KIND_SINT, 1);
        send_item(ACT_MOD, -7, 2, 1, KIND_SINT, 1);
        send_item(ACT_AND, -1, SMAX, 1, KIND_SINT, 8);
        send_item(ACT_OR, 127, 128, 1, KIND_SINT, 1);
        send_item(ACT_XOR, -1, 0, 1, KIND_SINT, 1);
        send_item(ACT_SHL, 1, 62, 1, KIND_SINT, 8);
        send_item(ACT_SHL, 2, 62, 1, KIND_SINT, 8);
        send_item(ACT_SHL, -1, 1, 1, KIND_SINT, 8);
        send_item(ACT_SHR, SMAX, 63, 1, KIND_SINT, 8);
        send_item(ACT_SHR, 100, -1, 1, KIND_SINT, 8);
        send_item(ACT_EQ, SMIN, SMIN, 0, 2'd3, 0);
        send_item(ACT_NE, 1, 2, 0, 2'd0, 15);
        send_item(ACT_LT, -1, 0, 0, KIND_SINT, 8);
        send_item(ACT_GE, SMAX, SMIN, 1, KIND_BOOL, 0);
        send_item(ACT_LAND, 3, 0, 0, KIND_BOOL, 4);
        send_item(ACT_LOR, 0, SMIN, 0, KIND_BOOL, 4);
        send_item(5'd31, 1, 1, 1, KIND_SINT, 8);
        send_item(ACT_ADD, 1, 0, 1, KIND_BOOL, 9);
        drain();

        send_idle = 8;
        recv_idle = 55;
        send_random(400);
        hold_cycles = 3 * LATENCY;
        send_random(200);
        drain();
        send_idle = 55;
        recv_idle = 8;
        send_random(300);
        send_idle = 0;
        recv_idle = 0;
        send_random(300);
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d items over all ALU actions, edge operands and result types;",
                 items_sent);
        $display("checked %0d results under idle, stall and backpressure phases.",
                 results_seen);
        if (fail_count == 0)
            $display("checked_constant_fold_alu: match");
        else
            $display("checked_constant_fold_alu: mismatch");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("checked_constant_fold_alu: mismatch");
        $finish;
    end

endmodule

// File: checked_constant_fold_alu.f
+incdir+rtl/core
rtl/core/cfa_pkg.sv
rtl/core/cfa_div_pipe.sv
rtl/core/checked_constant_fold_alu.sv
bench/fold_checker.sv
bench/tb_top.sv
